// ===== rtl/core/tmis_pkg.sv =====
// Shared types and constants for the tape machine instruction step core.
// Holds command characters, status and opcode codes, and port widths.
// No dependencies.
`default_nettype none

package tmis_pkg;

	// Default depths of the program store and the tape
	localparam int DEF_PROGRAM_DEPTH = 4096;
	localparam int DEF_TAPE_DEPTH    = 32768;

	// Port widths
	localparam int LEN_CFG_W  = 13;
	localparam int PROG_ADDR_W = 12;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 16;

	// Item kinds carried on s_tuser
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Command characters
	localparam logic [7:0] CH_RIGHT = 8'h3E; // '>'
	localparam logic [7:0] CH_LEFT  = 8'h3C; // '<'
	localparam logic [7:0] CH_INC   = 8'h2B; // '+'
	localparam logic [7:0] CH_DEC   = 8'h2D; // '-'
	localparam logic [7:0] CH_OUT   = 8'h2E; // '.'
	localparam logic [7:0] CH_IN    = 8'h2C; // ','
	localparam logic [7:0] CH_OPEN  = 8'h5B; // '['
	localparam logic [7:0] CH_CLOSE = 8'h5D; // ']'

	// Result status codes
	typedef logic [1:0] status_t;
	localparam status_t STATUS_RUN  = 2'd0;
	localparam status_t STATUS_HALT = 2'd1;
	localparam status_t STATUS_ERR  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/tape_machine_instruction_step_core.sv =====
// Top level of the tape machine instruction step core.
// Holds the program store, the tape memory and the step sequencer.
// Depends on tmis_pkg.
//
// Usage:
//   Slave stream (s_*) carries one item per transfer. s_tuser selects the
//   kind: OP_LOAD writes prog_byte at prog_addr into the program store,
//   OP_STEP executes the instruction at the program counter. Every item
//   yields exactly one result transfer on the master stream (m_*).
//   The cfg channel writes program_length (always ready).
// Sequencing:
//   A load goes from its transfer straight to the result state; a simple
//   step first passes through execute, with tape write-back, and then the
//   result state. A bracket jump adds a scan that reads the program memory
//   one address per cycle, walking from the bracket towards its partner
//   until it finds it or runs off the program.
//   One item is in flight at a time; s_tready is high only when idle.
// Reset:
//   arst_n clears the counters, the error flag and the length register,
//   then the tape is swept to zero, one cell per cycle, with s_tready low.
//   Configuration writes are taken during the sweep.
// Stall:
//   A result waits in the output register while m_tready is low; the core
//   still takes a new item and holds its own result until the slot frees.
`default_nettype none

module tape_machine_instruction_step_core #(
	parameter int PROGRAM_DEPTH = tmis_pkg::DEF_PROGRAM_DEPTH,
	parameter int TAPE_DEPTH    = tmis_pkg::DEF_TAPE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// cfg: program_length
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tmis_pkg::LEN_CFG_W-1:0] cfg_data,
	// s_tdata: prog_addr[11:0], prog_byte[19:12], in_byte[27:20], in_present[28], zero pad
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [tmis_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: opcode[0]
	input  wire logic [0:0]                     s_tuser,
	// m_tdata: out_valid[0], out_byte[8:1], input_used[9], status[11:10], zero pad
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [tmis_pkg::M_TDATA_W-1:0]      m_tdata
);
	import tmis_pkg::*;

	localparam int PA_W  = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
	localparam int PC_W  = $clog2(PROGRAM_DEPTH + 1);
	localparam int TP_W  = $clog2(TAPE_DEPTH);
	localparam int LEN_W = (LEN_CFG_W > PC_W) ? LEN_CFG_W : PC_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_RESP
	} state_t;

	state_t                 state_q;
	logic [LEN_CFG_W-1:0]   len_cfg_q;
	logic [PC_W-1:0]        pc_q;
	logic [TP_W-1:0]        tp_q;
	logic                   err_q;
	logic [TP_W-1:0]        clr_q;
	logic [7:0]             in_byte_q;
	logic                   in_present_q;
	logic                   res_ov_q;
	logic [7:0]             res_ob_q;
	logic                   res_iu_q;
	logic [PC_W-1:0]        scan_addr_q;
	logic                   scan_fwd_q;
	logic [PC_W-1:0]        depth_q;
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;

	// Memories
	logic [7:0]             prog_mem [PROGRAM_DEPTH];
	logic [7:0]             tape_mem [TAPE_DEPTH];
	logic [7:0]             prog_rd_q;
	logic [7:0]             tape_rd_q;

	logic                   prog_we, prog_re;
	logic [PA_W-1:0]        prog_wa, prog_ra;
	logic                   tape_we, tape_re;
	logic [TP_W-1:0]        tape_wa;
	logic [7:0]             tape_wd;

	// Input fields
	logic                   s_acc;
	logic                   f_opcode;
	logic [PROG_ADDR_W-1:0] f_prog_addr;
	logic [7:0]             f_prog_byte;
	logic [7:0]             f_in_byte;
	logic                   f_in_present;

	// Derived control
	logic [LEN_W-1:0]       len_ext, eff_len;
	logic                   pc_end;
	logic [PC_W-1:0]        pc_inc, pc_dec;
	logic                   fwd_end;
	logic [PC_W-1:0]        scan_next;
	logic                   scan_at_end;
	logic                   scan_match;
	logic                   scan_nest;
	logic                   scan_unnest;
	logic                   open_jump;
	logic                   close_jump;
	logic                   start_scan;
	status_t                cur_status;

	assign f_prog_addr  = s_tdata[11:0];
	assign f_prog_byte  = s_tdata[19:12];
	assign f_in_byte    = s_tdata[27:20];
	assign f_in_present = s_tdata[28];
	assign f_opcode     = s_tuser[0];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Oversized lengths clamp to the program store depth
	assign len_ext = LEN_W'(len_cfg_q);
	assign eff_len = (len_ext > LEN_W'(PROGRAM_DEPTH)) ? LEN_W'(PROGRAM_DEPTH) : len_ext;
	assign pc_end  = LEN_W'(pc_q) >= eff_len;
	assign pc_inc  = pc_q + PC_W'(1);
	assign pc_dec  = pc_q - PC_W'(1);
	assign fwd_end = LEN_W'(pc_inc) >= eff_len;

	assign cur_status = err_q ? STATUS_ERR : (pc_end ? STATUS_HALT : STATUS_RUN);

	// Taken brackets hold the counter; a scan starts when there is room to walk
	assign open_jump  = (prog_rd_q == CH_OPEN) && (tape_rd_q == 8'd0);
	assign close_jump = (prog_rd_q == CH_CLOSE) && (tape_rd_q != 8'd0);
	assign start_scan = (open_jump && !fwd_end) || (close_jump && (pc_q != '0));

	// Bracket scan: forward looks for ']' and nests on '[', backward the reverse
	assign scan_nest   = scan_fwd_q ? (prog_rd_q == CH_OPEN) : (prog_rd_q == CH_CLOSE);
	assign scan_unnest = scan_fwd_q ? (prog_rd_q == CH_CLOSE) : (prog_rd_q == CH_OPEN);
	assign scan_match  = scan_unnest && (depth_q == '0);
	assign scan_next   = scan_fwd_q ? (scan_addr_q + PC_W'(1)) : (scan_addr_q - PC_W'(1));
	assign scan_at_end = scan_fwd_q ? (LEN_W'(scan_next) >= eff_len) : (scan_addr_q == '0);

	// Program writes come only from load transfers; out-of-range addresses drop
	assign prog_we = s_acc && (f_opcode == OP_LOAD)
		&& (32'(f_prog_addr) < 32'(PROGRAM_DEPTH));
	assign prog_wa = PA_W'(f_prog_addr);

	// Memory port control
	always_comb begin
		prog_re = 1'b0;
		prog_ra = pc_q[PA_W-1:0];
		tape_re = 1'b0;
		tape_we = 1'b0;
		tape_wa = tp_q;
		tape_wd = tape_rd_q;
		unique case (state_q)
			ST_CLEAR: begin
				tape_we = 1'b1;
				tape_wa = clr_q;
				tape_wd = '0;
			end
			ST_IDLE: begin
				if (s_acc && (f_opcode == OP_STEP) && !err_q && !pc_end) begin
					prog_re = 1'b1;
					tape_re = 1'b1;
				end
			end
			ST_EXEC: begin
				unique case (prog_rd_q)
					CH_INC: begin
						tape_we = 1'b1;
						tape_wd = tape_rd_q + 8'd1;
					end
					CH_DEC: begin
						tape_we = 1'b1;
						tape_wd = tape_rd_q - 8'd1;
					end
					CH_IN: begin
						tape_we = in_present_q;
						tape_wd = in_byte_q;
					end
					CH_OPEN: begin
						if (tape_rd_q == 8'd0 && !fwd_end) begin
							prog_re = 1'b1;
							prog_ra = pc_inc[PA_W-1:0];
						end
					end
					CH_CLOSE: begin
						if (tape_rd_q != 8'd0 && pc_q != '0) begin
							prog_re = 1'b1;
							prog_ra = pc_dec[PA_W-1:0];
						end
					end
					default: begin
					end
				endcase
			end
			ST_SCAN: begin
				if (!scan_match && !scan_at_end) begin
					prog_re = 1'b1;
					prog_ra = scan_next[PA_W-1:0];
				end
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Program store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (prog_we) begin
			prog_mem[prog_wa] <= f_prog_byte;
		end
		if (prog_re) begin
			prog_rd_q <= prog_mem[prog_ra];
		end
	end

	// Tape: read in the fetch cycle, written back in the execute cycle
	always_ff @(posedge clk) begin
		if (tape_we) begin
			tape_mem[tape_wa] <= tape_wd;
		end
		if (tape_re) begin
			tape_rd_q <= tape_mem[tp_q];
		end
	end

	// Sequencer, architectural state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			len_cfg_q    <= '0;
			pc_q         <= '0;
			tp_q         <= '0;
			err_q        <= 1'b0;
			clr_q        <= '0;
			in_byte_q    <= '0;
			in_present_q <= 1'b0;
			res_ov_q     <= 1'b0;
			res_ob_q     <= '0;
			res_iu_q     <= 1'b0;
			scan_addr_q  <= '0;
			scan_fwd_q   <= 1'b0;
			depth_q      <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			if (cfg_valid) begin
				len_cfg_q <= cfg_data;
			end
			// offer the result once the output register is free; drop it once taken
			if (state_q == ST_RESP && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= M_TDATA_W'({cur_status, res_iu_q, res_ob_q, res_ov_q});
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + TP_W'(1);
					if (clr_q == TP_W'(TAPE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						res_ov_q     <= 1'b0;
						res_ob_q     <= '0;
						res_iu_q     <= 1'b0;
						in_byte_q    <= f_in_byte;
						in_present_q <= f_in_present;
						if (f_opcode == OP_STEP && !err_q && !pc_end) begin
							state_q <= ST_EXEC;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_EXEC: begin
					// a taken bracket holds the counter on itself
					if (!open_jump && !close_jump) begin
						pc_q <= pc_inc;
					end
					state_q <= start_scan ? ST_SCAN : ST_RESP;
					unique case (prog_rd_q)
						CH_RIGHT: begin
							tp_q <= (tp_q == TP_W'(TAPE_DEPTH - 1)) ? '0 : tp_q + TP_W'(1);
						end
						CH_LEFT: begin
							tp_q <= (tp_q == '0) ? TP_W'(TAPE_DEPTH - 1) : tp_q - TP_W'(1);
						end
						CH_OUT: begin
							res_ov_q <= 1'b1;
							res_ob_q <= tape_rd_q;
						end
						CH_IN: begin
							res_iu_q <= in_present_q;
						end
						CH_OPEN: begin
							if (open_jump) begin
								if (fwd_end) begin
									err_q <= 1'b1;
								end else begin
									scan_addr_q <= pc_inc;
									scan_fwd_q  <= 1'b1;
									depth_q     <= '0;
								end
							end
						end
						CH_CLOSE: begin
							if (close_jump) begin
								if (pc_q == '0) begin
									err_q <= 1'b1;
								end else begin
									scan_addr_q <= pc_dec;
									scan_fwd_q  <= 1'b0;
									depth_q     <= '0;
								end
							end
						end
						default: begin
						end
					endcase
				end
				ST_SCAN: begin
					if (scan_match) begin
						// land just past the matching bracket
						pc_q    <= scan_addr_q + PC_W'(1);
						state_q <= ST_RESP;
					end else if (scan_at_end) begin
						err_q   <= 1'b1;
						state_q <= ST_RESP;
					end else begin
						if (scan_nest) begin
							depth_q <= depth_q + PC_W'(1);
						end else if (scan_unnest) begin
							depth_q <= depth_q - PC_W'(1);
						end
						scan_addr_q <= scan_next;
					end
				end
				ST_RESP: begin
					// hold the result until the output register is free
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tmis_port_chk.sv =====
// Port-level checker for the tape machine instruction step core, with bind.
// Watches the result stream over time. Depends on tmis_pkg.
`default_nettype none

module tmis_port_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [tmis_pkg::M_TDATA_W-1:0] m_tdata
);
	import tmis_pkg::*;

	// no result is offered while reset is held
	a_no_result_in_reset: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result offered during reset");

	// a stalled result holds
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// status is one of the three defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11:10] == STATUS_RUN || m_tdata[11:10] == STATUS_HALT
			|| m_tdata[11:10] == STATUS_ERR))
		else $error("undefined status code");

	// output and input use are exclusive, and an absent output byte is zero
	a_io_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[9]) && (m_tdata[0] || m_tdata[8:1] == 8'd0))
		else $error("inconsistent output and input flags");

	// an error result never carries an output byte or consumed input
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[11:10] == STATUS_ERR |-> !m_tdata[0] && !m_tdata[9])
		else $error("error result with side effects");

endmodule

bind tape_machine_instruction_step_core tmis_port_chk u_tmis_port_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for tape_machine_instruction_step_core.
// Builds balanced tape-machine programs, runs them step by step and checks
// every result against an in-bench model of the machine. Depends on tmis_pkg.
`timescale 1ns / 100ps

module testbench;
	import tmis_pkg::*;

	localparam int TAPE_LAST   = DEF_TAPE_DEPTH - 1;
	localparam int QUIET_LIMIT = 200000;	// covers the tape sweep after reset
	localparam int SPACE_END   = 1500;		// new programs start at or below this address
	localparam int NOISE_BASE  = 2048;		// stray loads land at or above this

	typedef struct packed {
		logic       opcode;
		logic [11:0] prog_addr;
		logic [7:0] prog_byte;
		logic [7:0] in_byte;
		logic       in_present;
	} step_item_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       input_used;
		status_t    status;
	} step_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LEN_CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// Machine image kept by the bench: program, tape, registers
	logic [7:0] prog_mem [DEF_PROGRAM_DEPTH];
	logic [7:0] tape [DEF_TAPE_DEPTH];
	int pc = 0;
	int tp = 0;
	logic fault = 1'b0;
	int len_reg = 0;

	step_item_t   queued_commands [$];
	step_result_t step_outcomes [$];
	step_item_t   offered;
	logic [7:0]   program_text [$];

	int commands_sent = 0;
	int commands_taken = 0;
	int outcomes_seen = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	tape_machine_instruction_step_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Machine model
	// ------------------------------------------------------------------

	// A length above the store depth acts as the full store.
	function automatic int eff_len();
		return (len_reg > DEF_PROGRAM_DEPTH) ? DEF_PROGRAM_DEPTH : len_reg;
	endfunction

	function automatic status_t machine_status();
		if (fault)
			return STATUS_ERR;
		if (pc >= eff_len())
			return STATUS_HALT;
		return STATUS_RUN;
	endfunction

	// Matching ']' for the '[' at pos, searched only below lim; -1 if none.
	function automatic int find_close(input int pos, input int lim);
		int depth;
		depth = 0;
		for (int a = pos + 1; a < lim; a++) begin
			if (prog_mem[a] == CH_OPEN) begin
				depth++;
			end else if (prog_mem[a] == CH_CLOSE) begin
				if (depth == 0)
					return a;
				depth--;
			end
		end
		return -1;
	endfunction

	// Matching '[' for the ']' at pos, searched down to address 0; -1 if none.
	function automatic int find_open(input int pos);
		int depth;
		depth = 0;
		for (int a = pos - 1; a >= 0; a--) begin
			if (prog_mem[a] == CH_CLOSE) begin
				depth++;
			end else if (prog_mem[a] == CH_OPEN) begin
				if (depth == 0)
					return a;
				depth--;
			end
		end
		return -1;
	endfunction

	// Apply one accepted command to the image and queue the result it owes.
	task automatic execute_command(input step_item_t it);
		step_result_t r;
		int lim;
		int nxt;
		int hit;
		logic [7:0] cur_byte;
		r = '0;
		lim = eff_len();
		if (it.opcode == OP_LOAD) begin
			prog_mem[it.prog_addr] = it.prog_byte;
		end else if (!fault && pc < lim) begin
			nxt = pc + 1;
			cur_byte = tape[tp];
			case (prog_mem[pc])
				CH_RIGHT: tp = (tp == TAPE_LAST) ? 0 : tp + 1;
				CH_LEFT:  tp = (tp == 0) ? TAPE_LAST : tp - 1;
				CH_INC:   tape[tp] = cur_byte + 8'd1;
				CH_DEC:   tape[tp] = cur_byte - 8'd1;
				CH_OUT: begin
					r.out_valid = 1'b1;
					r.out_byte = cur_byte;
				end
				CH_IN: begin
					if (it.in_present) begin
						tape[tp] = it.in_byte;
						r.input_used = 1'b1;
					end
				end
				CH_OPEN: begin
					if (cur_byte == 8'd0) begin
						hit = find_close(pc, lim);
						if (hit < 0)
							fault = 1'b1;
						else
							nxt = hit + 1;
					end
				end
				CH_CLOSE: begin
					if (cur_byte != 8'd0) begin
						hit = find_open(pc);
						if (hit < 0)
							fault = 1'b1;
						else
							nxt = hit + 1;
					end
				end
				default: ;
			endcase
			// a failed scan leaves the counter on the bracket
			if (!fault)
				pc = nxt;
		end
		r.status = machine_status();
		step_outcomes.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Driver: offer queued commands, idle at random between transfers
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			execute_command(offered);
			commands_taken++;
		end
		// advance only once the slot is free; hold the offer otherwise
		if (!s_tvalid || s_tready) begin
			if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				offered = queued_commands.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {3'b000, offered.in_present, offered.in_byte,
					offered.prog_byte, offered.prog_addr};
				s_tuser <= offered.opcode;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each result transfer with the oldest owed result
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] result %0d: %s got 'h%0h, want 'h%0h",
			$realtime, outcomes_seen, what, got, want);
		mismatches++;
	endtask

	task automatic check_outcome(input logic [M_TDATA_W-1:0] word);
		step_result_t want;
		if (step_outcomes.size() == 0) begin
			report_mismatch("result with nothing owed, word", int'(word), 0);
		end else begin
			want = step_outcomes.pop_front();
			if (word[0] !== want.out_valid)
				report_mismatch("out_valid", int'(word[0]), int'(want.out_valid));
			if (word[8:1] !== want.out_byte)
				report_mismatch("out_byte", int'(word[8:1]), int'(want.out_byte));
			if (word[9] !== want.input_used)
				report_mismatch("input_used", int'(word[9]), int'(want.input_used));
			if (word[11:10] !== want.status)
				report_mismatch("status", int'(word[11:10]), int'(want.status));
		end
		outcomes_seen++;
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			check_outcome(m_tdata);
		m_tready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: end the run after too long without any transfer.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tape_machine_instruction_step_core regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Queue one command and hold until it is taken, so the image is current
	// when the next command is chosen.
	task automatic send_command(input step_item_t it);
		queued_commands.push_back(it);
		commands_sent++;
		wait (commands_taken == commands_sent);
	endtask

	task automatic send_load(input int addr, input logic [7:0] value);
		step_item_t it;
		it.opcode = OP_LOAD;
		it.prog_addr = 12'(addr);
		it.prog_byte = value;
		it.in_byte = 8'($urandom_range(255));
		it.in_present = 1'($urandom_range(1));
		send_command(it);
	endtask

	task automatic send_step(input logic [7:0] in_value, input logic present);
		step_item_t it;
		it.opcode = OP_STEP;
		it.prog_addr = 12'($urandom_range(4095));
		it.prog_byte = 8'($urandom_range(255));
		it.in_byte = in_value;
		it.in_present = present;
		send_command(it);
	endtask

	// Stray load far above the program area, any byte.
	task automatic send_noise_load();
		send_load($urandom_range(NOISE_BASE, DEF_PROGRAM_DEPTH - 1), 8'($urandom_range(255)));
	endtask

	// Drain every owed result, then write the length register.
	task automatic write_length(input int value);
		wait (step_outcomes.size() == 0);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= LEN_CFG_W'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		len_reg = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic is_command(input logic [7:0] b);
		return b == CH_RIGHT || b == CH_LEFT || b == CH_INC || b == CH_DEC ||
			b == CH_OUT || b == CH_IN || b == CH_OPEN || b == CH_CLOSE;
	endfunction

	function automatic logic [7:0] filler_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (is_command(b));
		return b;
	endfunction

	// Body of a skipped block: never executed, only balanced brackets.
	task automatic append_junk();
		logic [7:0] b;
		repeat ($urandom_range(0, 3)) begin
			do
				b = 8'($urandom_range(255));
			while (b == CH_OPEN || b == CH_CLOSE);
			case ($urandom_range(2))
				0: program_text.push_back(b);
				1: begin
					program_text.push_back(CH_OPEN);
					program_text.push_back(CH_CLOSE);
				end
				default: begin
					program_text.push_back(CH_OPEN);
					program_text.push_back(b);
					program_text.push_back(CH_CLOSE);
				end
			endcase
		end
	endtask

	// One balanced token. Loops are counted: ',' loads the counter (fed a
	// small byte when stepped), the body works one cell to the right and
	// never writes the counter, so every loop ends. A loop may be followed
	// by a block entered on a zero cell, which exercises the forward scan.
	task automatic append_token(input int depth);
		case ($urandom_range(0, (depth < 2) ? 9 : 6))
			0: program_text.push_back(CH_INC);
			1: program_text.push_back(CH_DEC);
			2: program_text.push_back(CH_OUT);
			3: program_text.push_back(CH_IN);
			4: program_text.push_back(filler_byte());
			5: begin
				program_text.push_back(CH_RIGHT);
				if (depth != 0)
					program_text.push_back(CH_LEFT);
			end
			6: begin
				program_text.push_back(CH_LEFT);
				if (depth != 0)
					program_text.push_back(CH_RIGHT);
			end
			default: begin
				program_text.push_back(CH_IN);
				program_text.push_back(CH_OPEN);
				program_text.push_back(CH_RIGHT);
				repeat ($urandom_range(1, 3))
					append_token(depth + 1);
				program_text.push_back(CH_LEFT);
				program_text.push_back(CH_DEC);
				program_text.push_back(CH_CLOSE);
				if ($urandom_range(1)) begin
					program_text.push_back(CH_OPEN);
					append_junk();
					program_text.push_back(CH_CLOSE);
				end
			end
		endcase
	endtask

	// Step until the machine leaves the running state, then a few steps
	// past the end. A ',' that opens a loop gets a small present byte.
	task automatic run_until_halt();
		int guard;
		guard = 0;
		while (machine_status() == STATUS_RUN && guard < 5000) begin
			if ($urandom_range(7) == 0)
				send_noise_load();
			if (prog_mem[pc] == CH_IN && pc + 1 < DEF_PROGRAM_DEPTH &&
					prog_mem[pc + 1] == CH_OPEN)
				send_step(8'($urandom_range(1, 3)), 1'b1);
			else
				send_step(8'($urandom_range(255)), $urandom_range(3) != 0);
			guard++;
		end
		repeat ($urandom_range(0, 2))
			send_step(8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	// Up to SPACE_END, place a fresh program at the halted counter and run it,
	// sometimes in two parts: length cut short first, then raised to resume.
	task automatic run_program();
		int base;
		int split;
		int n_tokens;
		if (pc > SPACE_END) begin
			send_noise_load();
			send_step(8'($urandom_range(255)), 1'($urandom_range(1)));
		end else begin
			program_text.delete();
			split = 0;
			n_tokens = $urandom_range(3, 6);
			for (int i = 0; i < n_tokens; i++) begin
				if (i == n_tokens / 2 && $urandom_range(2) == 0)
					split = program_text.size();
				append_token(0);
			end
			base = pc;
			foreach (program_text[i]) begin
				if ($urandom_range(9) == 0)
					send_noise_load();
				send_load(base + i, program_text[i]);
			end
			if (split != 0) begin
				write_length(base + split);
				run_until_halt();
			end
			write_length(base + program_text.size());
			run_until_halt();
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [7:0] opening [12];
		int base;

		foreach (prog_mem[i])
			prog_mem[i] = 8'd0;
		foreach (tape[i])
			tape[i] = 8'd0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 32;
		stall_pct = 86;

		// Length zero after reset: the machine reports halted.
		send_step(8'h00, 1'b0);
		send_load(DEF_PROGRAM_DEPTH - 1, 8'hFF);

		// Pointer wrap both ways, cell wrap below zero, output, end of
		// input, a nested skip, then a present input byte.
		opening = '{CH_LEFT, CH_DEC, CH_OUT, CH_RIGHT, CH_IN, CH_OUT,
			CH_OPEN, CH_OPEN, CH_CLOSE, CH_CLOSE, CH_IN, CH_OUT};
		foreach (opening[i])
			send_load(i, opening[i]);
		send_load(NOISE_BASE, 8'h00);
		write_length(12);
		send_step(8'hFF, 1'b1);
		send_step(8'h00, 1'b0);
		send_step(8'hFF, 1'b0);
		send_step(8'h00, 1'b1);
		send_step(8'h5A, 1'b0);
		send_step(8'hFF, 1'b1);
		send_step(8'h00, 1'b0);
		send_step(8'hC3, 1'b1);
		send_step(8'h3C, 1'b1);
		send_step(8'hA5, 1'b1);

		// Random programs under three idle patterns.
		while (commands_sent < 370)
			run_program();

		send_idle_pct = 86;
		stall_pct = 32;
		// Length register extremes with noise loads: oversized, full, shrunk, then a step.
		write_length((1 << LEN_CFG_W) - 1);
		send_noise_load();
		write_length(DEF_PROGRAM_DEPTH + 1);
		send_noise_load();
		write_length(DEF_PROGRAM_DEPTH);
		send_noise_load();
		write_length(1);
		send_noise_load();
		send_step(8'($urandom_range(255)), 1'b1);
		write_length(pc);
		while (commands_sent < 720)
			run_program();

		send_idle_pct = 0;
		stall_pct = 0;
		while (commands_sent < 1050)
			run_program();

		// Unmatched bracket last, since the error holds until reset:
		// a ']' on a nonzero cell or a '[' on a zero one finds no partner.
		wait (step_outcomes.size() == 0);
		base = pc;
		if (tape[tp] != 8'd0) begin
			send_load(base, CH_CLOSE);
			write_length(base + 1);
		end else begin
			send_load(base, CH_OPEN);
			send_load(base + 1, filler_byte());
			write_length(base + 2);
		end
		repeat (4)
			send_step(8'($urandom_range(255)), 1'($urandom_range(1)));
		send_noise_load();
		send_step(8'($urandom_range(255)), 1'($urandom_range(1)));

		// Drain, then let a few more cycles pass for stray results.
		wait (step_outcomes.size() == 0);
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("tape_machine_instruction_step_core regression: pass");
		else
			$display("tape_machine_instruction_step_core regression: fail");
		$finish;
	end

endmodule
